FILE: design/pdtg_pkg.sv
// ----------------------------------------------------------------------------
// pdtg_pkg
// Shared widths, codes and types of the path distance trigger generator.
// ----------------------------------------------------------------------------
package pdtg_pkg;

  // Field widths
  localparam int unsigned LenW    = 25;  // signed segment length
  localparam int unsigned SpeedW  = 14;  // speed and interval registers
  localparam int unsigned DistW   = 2 * SpeedW;  // speed * interval product
  localparam int unsigned PosW    = 32;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned SegW    = 16;
  localparam int unsigned CountW  = 32;
  localparam int unsigned KindW   = 2;
  localparam int unsigned ErrW    = 2;
  localparam int unsigned CfgIdxW = 2;

  // Register reset values and default trigger limit
  localparam logic [SpeedW-1:0] SpeedReset    = SpeedW'(100);
  localparam logic [SpeedW-1:0] IntervalReset = SpeedW'(10);
  localparam int unsigned       MaxTriggersDef = 63;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SPEED    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_INTERVAL = CfgIdxW'(1);

  // Result kinds
  typedef enum logic [KindW-1:0] {
    KIND_TRIGGER = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  // Error codes
  typedef enum logic [ErrW-1:0] {
    ERR_INVALID  = 2'd0,
    ERR_ZERO     = 2'd1,
    ERR_TOO_MANY = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_e;

  // Request to the shared divider
  typedef struct packed {
    logic              start;
    logic [PosW-1:0]   dividend;
    logic [SpeedW-1:0] divisor;
  } div_req_t;

endpackage

FILE: design/pdtg_if.sv
// ----------------------------------------------------------------------------
// pdtg interfaces
// Segment input, result output and configuration write channels.
// ----------------------------------------------------------------------------

// Segment channel
interface pdtg_seg_if;
  logic                                valid;
  logic                                ready;
  logic signed [pdtg_pkg::LenW-1:0]    segment_length_um;
  logic                                segment_valid;
  logic                                last_segment;

  modport source (output valid, segment_length_um, segment_valid, last_segment,
                  input ready);
  modport sink   (input valid, segment_length_um, segment_valid, last_segment,
                  output ready);
endinterface

// Result channel
interface pdtg_res_if;
  logic                          valid;
  logic                          ready;
  logic [pdtg_pkg::KindW-1:0]    kind;
  logic [pdtg_pkg::PosW-1:0]     position_um;
  logic [pdtg_pkg::TimeW-1:0]    time_ms;
  logic [pdtg_pkg::SegW-1:0]     seg_idx;
  logic [pdtg_pkg::CountW-1:0]   trig_total;
  logic [pdtg_pkg::ErrW-1:0]     error_code;
  logic                          last;

  modport source (output valid, kind, position_um, time_ms, seg_idx,
                  trig_total, error_code, last, input ready);
  modport sink   (input valid, kind, position_um, time_ms, seg_idx,
                  trig_total, error_code, last, output ready);
endinterface

// Configuration write channel
interface pdtg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pdtg_pkg::CfgIdxW-1:0]    index;
  logic [pdtg_pkg::SpeedW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/pdtg_div.sv
// ----------------------------------------------------------------------------
// pdtg_div
// Shared restoring divider: 32-bit dividend by 14-bit divisor, one quotient
// bit per cycle. done_o pulses one cycle with the quotient on quot_o.
// ----------------------------------------------------------------------------
module pdtg_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pdtg_pkg::div_req_t              req_i,
  output logic                            done_o,
  output logic [pdtg_pkg::PosW-1:0]       quot_o
);

  localparam int unsigned NW   = pdtg_pkg::PosW;
  localparam int unsigned DW   = pdtg_pkg::SpeedW;
  localparam int unsigned CntW = $clog2(NW);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   dvs_q;

  logic [DW:0]     trial;
  logic            ge;
  logic [DW:0]     diff;
  logic [DW-1:0]   rem_d;

  // One restoring step
  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    ge    = (trial >= {1'b0, dvs_q});
    diff  = trial - {1'b0, dvs_q};
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  // Checks
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q))
    else $error("divider done without a running division");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (req_i.divisor != '0))
    else $error("divider started with zero divisor");

endmodule

FILE: design/path_distance_trigger_generator.sv
// ----------------------------------------------------------------------------
// path_distance_trigger_generator
// Places a trigger every speed*interval um along a path of segments and
// reports trigger points, a path summary or an error.
// ----------------------------------------------------------------------------
// Usage:
//   seg_i : one path segment per request (signed length, valid, last flag).
//   res_o : result requests: trigger points, an error if a segment fails,
//           else a summary on the last one; a segment's last result has last set.
//   cfg_i : register writes (speed, interval), always ready; write only
//           while the block is idle.
// Sequence: a segment passes through setup (accept, multiply, span, check).
//   With triggers, one division gives the first trigger time, then one
//   trigger is sent per cycle while the receiver takes results (time steps
//   by the interval). A summary takes another division on the shared
//   iterative divider. Segments of a failed path are accepted and dropped.
// seg_i.ready is high only while the sequencer is idle. Results pass through
//   one output register; when the receiver stalls, the sequencer waits.
// Reset clears the path state and loads speed 100 mm/s, interval 10 ms.
// ----------------------------------------------------------------------------
module path_distance_trigger_generator #(
  parameter int unsigned MaxTriggers = pdtg_pkg::MaxTriggersDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  pdtg_seg_if.sink         seg_i,
  pdtg_res_if.source       res_o,
  pdtg_cfg_if.sink         cfg_i
);

  localparam int unsigned LenW   = pdtg_pkg::LenW;
  localparam int unsigned SpeedW = pdtg_pkg::SpeedW;
  localparam int unsigned DistW  = pdtg_pkg::DistW;
  localparam int unsigned PosW   = pdtg_pkg::PosW;
  localparam int unsigned NextW  = PosW + 1;
  localparam int unsigned MaxW   = $clog2(MaxTriggers + 1);
  localparam int unsigned SpanW  = DistW + MaxW;
  localparam int unsigned SumW   = ((SpanW > NextW) ? SpanW : NextW) + 1;
  localparam logic [MaxW-1:0] MaxTrig = MaxW'(MaxTriggers);

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_SPAN = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_DIVT = 4'd4;
  localparam logic [3:0] S_TRIG = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_DIVS = 4'd7;
  localparam logic [3:0] S_SUM  = 4'd8;
  localparam logic [3:0] S_ERR  = 4'd9;

  logic [3:0] state_q, state_d;

  // Configuration registers
  logic [SpeedW-1:0] spd_q, ivl_q;

  // Path state
  logic [PosW-1:0]             acc_q;
  logic [NextW-1:0]            next_q;
  logic [pdtg_pkg::CountW-1:0] trig_q;
  logic [pdtg_pkg::SegW-1:0]   segc_q;
  logic                        failed_q;

  // Per-segment working registers
  logic [LenW-1:0]     mag_q;
  logic                sv_q, last_q;
  logic [SpeedW-1:0]   espd_q, eivl_q;
  logic [DistW-1:0]    dist_q;
  logic [NextW-1:0]    end_q, nxt_q;
  logic [SpanW-1:0]    span_q;
  pdtg_pkg::err_e      err_q;
  logic [PosW-1:0]     time_q;

  // Output register
  logic                        out_valid_q;
  pdtg_pkg::kind_e             out_kind_q;
  logic [PosW-1:0]             out_pos_q;
  logic [pdtg_pkg::TimeW-1:0]  out_time_q;
  logic [pdtg_pkg::SegW-1:0]   out_seg_q;
  logic [pdtg_pkg::CountW-1:0] out_cnt_q;
  pdtg_pkg::err_e              out_err_q;
  logic                        out_last_q;

  // Sequencer outputs
  logic                        in_acc;
  logic                        emit_ok;
  logic                        emit;
  pdtg_pkg::kind_e             o_kind;
  logic [PosW-1:0]             o_pos;
  logic [pdtg_pkg::TimeW-1:0]  o_time;
  logic [pdtg_pkg::CountW-1:0] o_cnt;
  pdtg_pkg::err_e              o_err;
  logic                        o_last;
  logic                        end_path;

  pdtg_pkg::div_req_t  div_req;
  logic                div_done;
  logic [PosW-1:0]     div_quot;

  logic [LenW-1:0]     mag;
  logic [LenW-1:0]     raw;
  logic                nxt_le_end;
  logic                too_many;
  logic [NextW-1:0]    nxt_plus;
  logic                step_past;

  assign in_acc  = seg_i.valid & seg_i.ready;
  assign emit_ok = !out_valid_q || res_o.ready;
  assign seg_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Magnitude of the signed length
  assign raw = seg_i.segment_length_um;
  assign mag = raw[LenW-1] ? (~raw + 1'b1) : raw;

  // Trigger window checks
  assign nxt_le_end = (nxt_q <= end_q);
  assign too_many   = ((SumW'(nxt_q) + SumW'(span_q)) <= SumW'(end_q));
  assign nxt_plus   = nxt_q + NextW'(dist_q);
  assign step_past  = (nxt_plus > end_q);

  // Shared divider
  pdtg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Sequencer
  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = (state_q == S_FIN) ? acc_q : nxt_q[PosW-1:0];
    div_req.divisor  = espd_q;
    emit             = 1'b0;
    end_path         = 1'b0;
    o_kind           = pdtg_pkg::KIND_TRIGGER;
    o_pos            = nxt_q[PosW-1:0];
    o_time           = time_q;
    o_cnt            = '0;
    o_err            = pdtg_pkg::ERR_INVALID;
    o_last           = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (failed_q) begin
            end_path = seg_i.last_segment;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL:  state_d = S_SPAN;
      S_SPAN: state_d = S_CHK;
      S_CHK: begin
        if (!sv_q || end_q[NextW-1] || (nxt_le_end && too_many)) begin
          state_d = S_ERR;
        end else if (nxt_le_end) begin
          div_req.start = 1'b1;
          state_d       = S_DIVT;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIVT: begin
        if (div_done) state_d = S_TRIG;
      end
      S_TRIG: begin
        o_last = step_past && !last_q;
        if (emit_ok) begin
          emit = 1'b1;
          if (step_past) state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (acc_q == '0) begin
          // Path closed with nothing travelled
          o_kind = pdtg_pkg::KIND_ERROR;
          o_pos  = '0;
          o_time = '0;
          o_cnt  = trig_q;
          o_err  = pdtg_pkg::ERR_ZERO;
          o_last = 1'b1;
          if (emit_ok) begin
            emit     = 1'b1;
            end_path = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          div_req.start = 1'b1;
          state_d       = S_DIVS;
        end
      end
      S_DIVS: begin
        if (div_done) state_d = S_SUM;
      end
      S_SUM: begin
        o_kind = pdtg_pkg::KIND_SUMMARY;
        o_pos  = acc_q;
        o_cnt  = trig_q;
        o_last = 1'b1;
        if (emit_ok) begin
          emit     = 1'b1;
          end_path = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_ERR: begin
        o_kind = pdtg_pkg::KIND_ERROR;
        o_pos  = '0;
        o_time = '0;
        o_cnt  = trig_q;
        o_err  = err_q;
        o_last = 1'b1;
        if (emit_ok) begin
          emit     = 1'b1;
          end_path = last_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and path state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      spd_q       <= pdtg_pkg::SpeedReset;
      ivl_q       <= pdtg_pkg::IntervalReset;
      acc_q       <= '0;
      next_q      <= '0;
      trig_q      <= '0;
      segc_q      <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Register writes
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          pdtg_pkg::REG_SPEED:    spd_q <= cfg_i.data;
          pdtg_pkg::REG_INTERVAL: ivl_q <= cfg_i.data;
          default: ;
        endcase
      end

      // Segment without triggers: commit length
      if (state_q == S_CHK && state_d == S_FIN) begin
        acc_q  <= end_q[PosW-1:0];
        next_q <= nxt_q;
      end

      // Trigger sent
      if (state_q == S_TRIG && emit) begin
        trig_q <= trig_q + 1'b1;
        if (step_past) begin
          acc_q  <= end_q[PosW-1:0];
          next_q <= nxt_plus;
        end
      end

      if (state_q == S_FIN && !last_q) segc_q <= segc_q + 1'b1;
      if (state_q == S_ERR && emit && !last_q) failed_q <= 1'b1;

      if (end_path) begin
        acc_q    <= '0;
        next_q   <= '0;
        trig_q   <= '0;
        segc_q   <= '0;
        failed_q <= 1'b0;
      end

      // Output handshake
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Segment datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mag_q  <= mag;
      sv_q   <= seg_i.segment_valid;
      last_q <= seg_i.last_segment;
      espd_q <= (spd_q == '0) ? SpeedW'(1) : spd_q;
      eivl_q <= (ivl_q == '0) ? SpeedW'(1) : ivl_q;
    end
    if (state_q == S_MUL) begin
      dist_q <= espd_q * eivl_q;
      end_q  <= NextW'(acc_q) + NextW'(mag_q);
    end
    if (state_q == S_SPAN) begin
      nxt_q  <= (next_q != '0) ? next_q : NextW'(dist_q);
      span_q <= SpanW'(MaxTrig) * SpanW'(dist_q);
    end
    if (state_q == S_CHK) begin
      if (!sv_q) begin
        err_q <= pdtg_pkg::ERR_INVALID;
      end else if (end_q[NextW-1]) begin
        err_q <= pdtg_pkg::ERR_OVERFLOW;
      end else begin
        err_q <= pdtg_pkg::ERR_TOO_MANY;
      end
    end
    if ((state_q == S_DIVT || state_q == S_DIVS) && div_done) begin
      time_q <= div_quot;
    end
    // Next trigger: time steps by the interval since dist = speed * interval
    if (state_q == S_TRIG && emit) begin
      nxt_q  <= nxt_plus;
      time_q <= time_q + PosW'(eivl_q);
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q <= o_kind;
      out_pos_q  <= o_pos;
      out_time_q <= o_time;
      out_seg_q  <= segc_q;
      out_cnt_q  <= o_cnt;
      out_err_q  <= o_err;
      out_last_q <= o_last;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = out_kind_q;
  assign res_o.position_um = out_pos_q;
  assign res_o.time_ms     = out_time_q;
  assign res_o.seg_idx     = out_seg_q;
  assign res_o.trig_total  = out_cnt_q;
  assign res_o.error_code  = out_err_q;
  assign res_o.last        = out_last_q;

  // Checks
  a_trig_in_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TRIG) |-> (nxt_le_end && !end_q[NextW-1]))
    else $error("trigger position beyond segment end");

  a_summary_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && o_kind == pdtg_pkg::KIND_SUMMARY) |-> (acc_q != '0))
    else $error("summary sent with zero path length");

  a_failed_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> (state_q == S_IDLE))
    else $error("sequencer busy on a failed path");

endmodule
